// File: src/protection_region_envelope_assert.svh
// Assertion shorthands used by the checker of this block.
`ifndef PROTECTION_REGION_ENVELOPE_ASSERT_SVH
`define PROTECTION_REGION_ENVELOPE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pre_pkg.sv
`timescale 1ns / 1ps

package pre_pkg;

  localparam int FIELD_W      = 32;
  localparam int ADDR_W       = 32;
  localparam int SPAN_W       = ADDR_W + 1;
  localparam int K_W          = $clog2(ADDR_W + 1);
  localparam int INDEX_W      = 4;
  localparam int CODE_W       = 5;
  localparam int MASK_W       = 8;
  localparam int SUB_IDX_W    = $clog2(MASK_W);
  localparam int MIN_LOG2     = 5;
  localparam int SUB_MIN_LOG2 = 8;
  localparam int MAX_INDEX    = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_GROW,
    ST_FIT,
    ST_MASK_LO,
    ST_MASK_HI,
    ST_OUT
  } pre_state_t;

  typedef struct packed {
    logic [SPAN_W-1:0] a;
    logic [SPAN_W-1:0] b;
    logic [SPAN_W-1:0] c;
    logic              cin;
    logic              le;
  } pre_alu_req_t;

  typedef struct packed {
    logic [SPAN_W-1:0] sum;
    logic              hit;
  } pre_alu_rsp_t;

  typedef struct packed {
    logic              accepted;
    logic [FIELD_W-1:0] base_address;
    logic [CODE_W-1:0] size_code;
    logic [MASK_W-1:0] subregion_disable;
  } pre_res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } pre_seq_stat_t;

endpackage

// File: src/pre_alu.sv
`timescale 1ns / 1ps

module pre_alu
  import pre_pkg::*;
(
  input  pre_alu_req_t req,
  output pre_alu_rsp_t rsp
);

  logic [SPAN_W-1:0] sum;

  assign sum     = req.a + req.b + SPAN_W'(req.cin);
  assign rsp.sum = sum;
  assign rsp.hit = req.le ? (sum <= req.c) : (sum < req.c);

endmodule

// File: src/pre_seq.sv
`timescale 1ns / 1ps

module pre_seq
  import pre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [INDEX_W-1:0] region_index,
  input  logic [FIELD_W-1:0] start_address,
  input  logic [FIELD_W-1:0] end_address,
  input  logic               take,
  output pre_seq_stat_t      stat,
  output pre_res_t           res
);

  pre_state_t state, state_next;

  logic [INDEX_W-1:0]   idx;
  logic [ADDR_W-1:0]    start_a;
  logic [ADDR_W-1:0]    end_a;
  logic [ADDR_W-1:0]    span;
  logic [SPAN_W-1:0]    size;
  logic [ADDR_W-1:0]    lomask;
  logic [K_W-1:0]       k;
  logic [ADDR_W-1:0]    base;
  logic [SPAN_W-1:0]    sub;
  logic [SPAN_W-1:0]    s;
  logic [SUB_IDX_W-1:0] sub_idx;
  logic [MASK_W-1:0]    mask;
  logic                 acc;

  pre_alu_req_t req;
  pre_alu_rsp_t rsp;

  logic              span_ok;
  logic              can_grow;
  logic [ADDR_W-1:0] base_now;

  pre_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // A clear top bit of the difference (no borrow) and a nonzero difference
  // mean end is above start.
  assign span_ok  = !rsp.sum[ADDR_W] && (rsp.sum[ADDR_W-1:0] != '0) &&
                    (idx <= INDEX_W'(MAX_INDEX));
  assign can_grow = (k < K_W'(ADDR_W));
  assign base_now = start_a & ~lomask;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) state_next = ST_SPAN;
      end
      ST_SPAN: begin
        state_next = span_ok ? ST_GROW : ST_OUT;
      end
      ST_GROW: begin
        if (!(rsp.hit && can_grow)) state_next = ST_FIT;
      end
      ST_FIT: begin
        if (!(rsp.hit && can_grow)) begin
          state_next = (k >= K_W'(SUB_MIN_LOG2)) ? ST_MASK_LO : ST_OUT;
        end
      end
      ST_MASK_LO: state_next = ST_MASK_HI;
      ST_MASK_HI: begin
        if (sub_idx == SUB_IDX_W'(MASK_W - 1)) state_next = ST_OUT;
        else state_next = ST_MASK_LO;
      end
      ST_OUT: begin
        if (take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    case (state)
      ST_SPAN: begin
        req.a   = {1'b0, end_a};
        req.b   = ~{1'b0, start_a};
        req.cin = 1'b1;
      end
      ST_GROW: begin
        req.b = size;
        req.c = {1'b0, span};
      end
      ST_FIT: begin
        req.a = {1'b0, base_now};
        req.b = size;
        req.c = {1'b0, end_a};
      end
      ST_MASK_LO: begin
        req.a = s;
        req.c = {1'b0, end_a};
      end
      ST_MASK_HI: begin
        req.a  = s;
        req.b  = sub;
        req.c  = {1'b0, start_a};
        req.le = 1'b1;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (go) begin
          idx     <= region_index;
          start_a <= start_address[ADDR_W-1:0];
          end_a   <= end_address[ADDR_W-1:0];
          size    <= SPAN_W'(1) << MIN_LOG2;
          lomask  <= (ADDR_W'(1) << MIN_LOG2) - ADDR_W'(1);
          k       <= K_W'(MIN_LOG2);
          mask    <= '0;
          sub_idx <= '0;
        end
      end
      ST_SPAN: begin
        span <= rsp.sum[ADDR_W-1:0];
        acc  <= span_ok;
        base <= '0;
      end
      ST_GROW, ST_FIT: begin
        if (rsp.hit && can_grow) begin
          size   <= size << 1;
          lomask <= {lomask[ADDR_W-2:0], 1'b1};
          k      <= k + K_W'(1);
        end else if (state == ST_FIT) begin
          base <= base_now;
          s    <= {1'b0, base_now};
          sub  <= size >> 3;
        end
      end
      ST_MASK_LO: begin
        // The eighth begins at or past the end of the interval.
        if (!rsp.hit) mask[sub_idx] <= 1'b1;
      end
      ST_MASK_HI: begin
        // The eighth ends at or before the start of the interval.
        if (rsp.hit) mask[sub_idx] <= 1'b1;
        s       <= rsp.sum;
        sub_idx <= sub_idx + SUB_IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign stat.idle      = (state == ST_IDLE);
  assign stat.res_valid = (state == ST_OUT);

  assign res.accepted          = acc;
  assign res.base_address      = FIELD_W'(base);
  assign res.size_code         = acc ? CODE_W'(k - K_W'(1)) : '0;
  assign res.subregion_disable = mask;

endmodule

// File: src/protection_region_envelope.sv
`timescale 1ns / 1ps

// Fits a memory protection region around the byte interval [start, end).
// Input channel s_*: one transaction per request, carrying the region index
// in s_tuser and the start and exclusive end addresses in s_tdata.
// Output channel m_*: one transaction per request; m_tuser is the accepted
// flag and m_tdata holds the aligned base, the size code (log2 of the size
// minus one) and the subregion-disable mask. A rejected request returns
// all zeros in m_tdata.
// The block works on one request at a time: s_tready is high only while
// the sequencer is idle. A request first has its span computed; an accepted
// one then doubles the size through a single shared adder and comparator
// in two doubling passes, each closed by the compare that stops the growth,
// and builds the subregion mask when the region is 256 bytes or more (two
// compares per eighth).
// The result sits in an output register, so the next request is taken
// while it waits; if the receiver stalls, the following result is held in
// the sequencer until the register frees.
// Synchronous reset returns the sequencer to idle and drops m_tvalid.
module protection_region_envelope
  import pre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // [31:0] start_address, [63:32] end_address
  input  logic [3:0]  s_tuser,  // [3:0] region_index
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] base_address, [36:32] size_code, [44:37] subregion_disable, [47:45] zero
  output logic [47:0] m_tdata,
  output logic        m_tuser   // [0] accepted
);

  pre_seq_stat_t stat;
  pre_res_t      res;
  logic          take;

  assign s_tready = stat.idle;
  assign take     = stat.res_valid && (!m_tvalid || m_tready);

  pre_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .go            (s_tvalid && s_tready),
    .region_index  (s_tuser),
    .start_address (s_tdata[31:0]),
    .end_address   (s_tdata[63:32]),
    .take          (take),
    .stat          (stat),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {3'b000, res.subregion_disable, res.size_code, res.base_address};
      m_tuser <= res.accepted;
    end
  end

endmodule

// File: src/pre_checker.sv
`timescale 1ns / 1ps

`include "protection_region_envelope_assert.svh"

module pre_checker
  import pre_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  `PRE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `PRE_ASSERT_SAME(a_reject_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0, "rejected result not zero")
  `PRE_ASSERT_SAME(a_code_min, clk, rst, m_tvalid && m_tuser, m_tdata[36:32] >= 5'd4, "size code below minimum")
  `PRE_ASSERT_SAME(a_small_mask, clk, rst, m_tvalid && m_tuser && (m_tdata[36:32] < 5'd7), m_tdata[44:37] == '0, "mask set on small region")
  `PRE_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready, "took a second request while busy")

endmodule

bind protection_region_envelope pre_checker u_pre_checker (.*);
